[rtl/video_slice_reassembly_tracker_unit_defines.svh]
// assertion macros for the slice reassembly tracker
`ifndef VIDEO_SLICE_REASSEMBLY_TRACKER_UNIT_DEFINES_SVH
`define VIDEO_SLICE_REASSEMBLY_TRACKER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define VSRT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define VSRT_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define VSRT_ASSERT(label, cond, msg)
`define VSRT_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

[rtl/vsrt_pkg.sv]
// shared constants and types for the slice reassembly tracker
package vsrt_pkg;
  localparam int DEF_FRAME_SLOTS = 8;
  localparam int DEF_MAX_SLICES = 256;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [7:0] THRESH_RST = 8'd3;
  localparam logic [1:0] OP_PKT = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_DEC = 2'd2;
  localparam logic [2:0] K_ACC = 3'd0;
  localparam logic [2:0] K_DUP = 3'd1;
  localparam logic [2:0] K_CPL = 3'd2;
  localparam logic [2:0] K_TMO = 3'd3;
  localparam logic [2:0] K_DROP = 3'd4;
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_THRESH = 1'b1;
  // per-slot record held in the slot memory
  typedef struct packed {
    logic [15:0] fn;
    logic [31:0] total;
    logic [31:0] rx;
    logic [31:0] start;
    logic [15:0] dup;
  } slot_rec_t;
  localparam int REC_W = $bits(slot_rec_t);
endpackage

[rtl/vsrt_ram.sv]
// generic single-port-write ram with registered read
module vsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/video_slice_reassembly_tracker_unit.sv]
// top level of the video slice reassembly tracker
// Tracks up to FRAME_SLOTS partly received frames. Slot records (frame number,
// total, received bytes, start time, duplicates) live in one synchronous ram,
// the seen-slice bitmap in a second ram of one bit per slot and slice. Slot
// valid bits are flip-flops and frame matching runs against a small register
// copy of each slot's frame number. A packet header keeps busy high through
// record read, update, record write back with bitmap read and result, and
// the next word can be taken as soon as busy is low again. A dropped
// packet, a decode event or an ignored op leaves busy low; a dropped packet's
// result shows in the next cycle. A tick reads and then checks each slot in
// turn and ends with a final step, with busy high throughout. Results come out
// as one-cycle strobes on out_valid and cannot be stalled; a tick gives at most
// one timeout word per slot check, and the final one follows the scan.
// Claiming or restarting a slot wipes its bitmap row with a sweep over its
// MAX_SLICES bits, one bit a cycle; busy stays high for the sweep. No clearing
// pass after reset is needed.
`include "video_slice_reassembly_tracker_unit_defines.svh"
module video_slice_reassembly_tracker_unit #(
  parameter int FRAME_SLOTS = vsrt_pkg::DEF_FRAME_SLOTS,
  parameter int MAX_SLICES = vsrt_pkg::DEF_MAX_SLICES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_frame_id,
  input  logic [15:0] in_slice_id,
  input  logic [31:0] in_total_bytes,
  input  logic [15:0] in_payload_length,
  input  logic [31:0] in_now_ms,
  input  logic        in_decode_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [15:0] out_frame_number,
  output logic [2:0]  out_slot,
  output logic [15:0] out_slice_index,
  output logic [15:0] out_gap_count,
  output logic [31:0] out_received_total,
  output logic        out_length_mismatch,
  output logic [15:0] out_duplicate_count,
  output logic        out_decoder_reset,
  output logic        out_last
);
  import vsrt_pkg::*;

  localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int LW = $clog2(MAX_SLICES);
  localparam int MD = FRAME_SLOTS * MAX_SLICES;
  localparam int MW = $clog2(MD);

  typedef enum logic [3:0] {
    S_IDLE, S_PRD, S_PUPD, S_WIPE, S_SEEN, S_PFIN,
    S_TRD, S_TCHK, S_TEND
  } state_t;

  state_t state_r;
  logic [15:0] timeout_r;
  logic [7:0] thresh_r;
  logic [FRAME_SLOTS-1:0] valid_r;
  logic [15:0] fn_r [FRAME_SLOTS];
  logic [15:0] last_fn_r;
  logic [7:0] streak_r;

  // latched input word
  logic [15:0] fid_r, sid_r, plen_r;
  logic [31:0] tot_r, now_r;
  logic [SW-1:0] slot_r;
  logic [LW-1:0] wipe_r;
  logic claim_r;
  slot_rec_t rec_r;
  logic pend_r;  // a timeout word is held until the next eviction or the end
  logic [SW:0] tscan_r;
  // held timeout word
  logic [15:0] tmo_fn_r, tmo_dup_r;
  logic [2:0] tmo_slot_r;
  logic [31:0] tmo_rx_r;

  // rams
  logic rec_we, map_we, map_wd;
  logic [SW-1:0] rec_wa, rec_ra;
  slot_rec_t rec_wd, rec_rd;
  logic [MW-1:0] map_wa, map_ra;
  logic map_rd;

  vsrt_ram #(.WIDTH(REC_W), .DEPTH(1 << SW)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
    .raddr(rec_ra), .rdata(rec_rd));
  vsrt_ram #(.WIDTH(1), .DEPTH(1 << MW)) u_map (
    .clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
    .raddr(map_ra), .rdata(map_rd));

  // slot match and free search over the frame-number registers
  logic hit, free_any;
  logic [SW-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && fn_r[i] == in_frame_id) begin
        hit = 1'b1;
        hit_idx = SW'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // streak step shared by completion and tick end
  logic [7:0] streak_inc;
  logic streak_fire;
  assign streak_inc = (streak_r == 8'hFF) ? streak_r : streak_r + 8'd1;
  assign streak_fire = streak_inc >= thresh_r;

  logic [32:0] sum;
  logic [31:0] rx_sat;
  assign sum = {1'b0, rec_r.rx} + {17'd0, plen_r};
  assign rx_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  logic [15:0] expect_fn, gap_raw;
  assign expect_fn = last_fn_r + 16'd1;
  assign gap_raw = fid_r - expect_fn;
  logic tick_old;
  logic [31:0] age;
  assign age = now_r - rec_rd.start;
  assign tick_old = age > {16'd0, timeout_r};

  assign rec_ra = (state_r == S_IDLE) ? (hit ? hit_idx : free_idx) : tscan_r[SW-1:0];
  assign map_ra = MW'({slot_r, sid_r[LW-1:0]});

  always_comb begin
    rec_we = 1'b0;
    rec_wa = slot_r;
    rec_wd = rec_r;
    map_we = 1'b0;
    map_wa = MW'({slot_r, wipe_r});
    map_wd = 1'b0;
    case (state_r)
      S_WIPE: map_we = 1'b1;
      S_PFIN: begin
        if (!map_rd) begin
          map_we = 1'b1;
          map_wa = MW'({slot_r, sid_r[LW-1:0]});
          map_wd = 1'b1;
          rec_we = 1'b1;
          rec_wd.rx = rx_sat;
        end else begin
          rec_we = 1'b1;
          rec_wd.dup = (rec_r.dup == 16'hFFFF) ? rec_r.dup : rec_r.dup + 16'd1;
        end
      end
      S_SEEN: begin
        rec_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      timeout_r <= TIMEOUT_RST;
      thresh_r <= THRESH_RST;
      valid_r <= '0;
      last_fn_r <= '0;
      streak_r <= '0;
      out_valid <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_data;
          CFG_THRESH: thresh_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            fid_r <= in_frame_id;
            sid_r <= in_slice_id;
            tot_r <= in_total_bytes;
            plen_r <= in_payload_length;
            now_r <= in_now_ms;
            slot_r <= hit ? hit_idx : free_idx;
            claim_r <= !hit;
            tscan_r <= '0;
            pend_r <= 1'b0;
            case (in_op)
              OP_PKT: begin
                if (in_payload_length == 16'd0 || {16'd0, in_slice_id} >= MAX_SLICES
                    || (!hit && !free_any)) begin
                  out_valid <= 1'b1;
                  out_kind <= K_DROP;
                  out_frame_number <= in_frame_id;
                  out_slot <= '0;
                  out_slice_index <= in_slice_id;
                  out_gap_count <= '0;
                  out_received_total <= '0;
                  out_length_mismatch <= 1'b0;
                  out_duplicate_count <= '0;
                  out_decoder_reset <= 1'b0;
                  out_last <= 1'b1;
                end else begin
                  state_r <= S_PRD;
                end
              end
              OP_TICK: state_r <= S_TRD;
              OP_DEC: if (in_decode_ok) streak_r <= '0;
              default: ;
            endcase
          end
        end
        S_PRD: begin
          // record read lands now
          rec_r <= rec_rd;
          state_r <= S_PUPD;
        end
        S_PUPD: begin
          wipe_r <= '0;
          if (claim_r) begin
            rec_r <= '{fn: fid_r, total: tot_r, rx: 32'd0, start: now_r, dup: 16'd0};
            valid_r[slot_r] <= 1'b1;
            fn_r[slot_r] <= fid_r;
            state_r <= S_WIPE;
          end else if (rec_r.total != tot_r) begin
            rec_r.total <= tot_r;
            rec_r.rx <= '0;
            rec_r.start <= now_r;
            state_r <= S_WIPE;
          end else begin
            state_r <= S_SEEN;
          end
        end
        S_WIPE: begin
          wipe_r <= wipe_r + 1'b1;
          if (wipe_r == LW'(MAX_SLICES - 1)) state_r <= S_SEEN;
        end
        S_SEEN: state_r <= S_PFIN;  // bitmap read issued, record committed
        S_PFIN: begin
          state_r <= S_IDLE;
          out_valid <= 1'b1;
          out_frame_number <= fid_r;
          out_slot <= 3'(slot_r);
          out_slice_index <= sid_r;
          out_gap_count <= '0;
          out_length_mismatch <= 1'b0;
          out_decoder_reset <= 1'b0;
          out_last <= 1'b1;
          if (map_rd) begin
            out_kind <= K_DUP;
            out_received_total <= rec_r.rx;
            out_duplicate_count <= rec_wd.dup;
          end else begin
            out_received_total <= rx_sat;
            out_duplicate_count <= rec_r.dup;
            if (rx_sat >= rec_r.total) begin
              out_kind <= K_CPL;
              out_length_mismatch <= rx_sat != rec_r.total;
              valid_r[slot_r] <= 1'b0;
              last_fn_r <= fid_r;
              if (last_fn_r != 16'd0 && fid_r != expect_fn) begin
                out_gap_count <= (gap_raw == 16'd0) ? 16'd1 : gap_raw;
                streak_r <= streak_fire ? 8'd0 : streak_inc;
                out_decoder_reset <= streak_fire;
              end
            end else begin
              out_kind <= K_ACC;
            end
          end
        end
        S_TRD: state_r <= S_TCHK;
        S_TCHK: begin
          // rec_rd holds slot tscan_r; emit previously held word on a new hit
          if (valid_r[tscan_r[SW-1:0]] && tick_old) begin
            valid_r[tscan_r[SW-1:0]] <= 1'b0;
            pend_r <= 1'b1;
            tmo_fn_r <= rec_rd.fn;
            tmo_slot_r <= 3'(tscan_r[SW-1:0]);
            tmo_rx_r <= rec_rd.rx;
            tmo_dup_r <= rec_rd.dup;
            if (pend_r) begin
              out_valid <= 1'b1;
              out_kind <= K_TMO;
              out_frame_number <= tmo_fn_r;
              out_slot <= tmo_slot_r;
              out_slice_index <= '0;
              out_gap_count <= '0;
              out_received_total <= tmo_rx_r;
              out_length_mismatch <= 1'b0;
              out_duplicate_count <= tmo_dup_r;
              out_decoder_reset <= 1'b0;
              out_last <= 1'b0;
            end
          end
          tscan_r <= tscan_r + 1'b1;
          state_r <= (tscan_r == (SW+1)'(FRAME_SLOTS - 1)) ? S_TEND : S_TRD;
        end
        S_TEND: begin
          state_r <= S_IDLE;
          if (pend_r) begin
            out_valid <= 1'b1;
            out_kind <= K_TMO;
            out_frame_number <= tmo_fn_r;
            out_slot <= tmo_slot_r;
            out_slice_index <= '0;
            out_gap_count <= '0;
            out_received_total <= tmo_rx_r;
            out_length_mismatch <= 1'b0;
            out_duplicate_count <= tmo_dup_r;
            out_last <= 1'b1;
            out_decoder_reset <= streak_fire;
            streak_r <= streak_fire ? 8'd0 : streak_inc;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `VSRT_ASSERT_IMPL(a_accept_idle, accept, state_r == S_IDLE, "accept outside idle")
  `VSRT_ASSERT_IMPL(a_out_last_idle, out_valid && out_last, state_r == S_IDLE,
      "last word while still working")
  `VSRT_ASSERT_IMPL(a_wipe_claimed, state_r == S_WIPE, valid_r[slot_r],
      "wiping a slot that is not held")
endmodule
